/* rtl/lfb_pkg.sv */
// Package with the shared types and byte constants of the link frame builder.
`timescale 1ns / 1ps
`default_nettype none

package lfb_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hA5;
    localparam logic [7:0] END_BYTE  = 8'hFE;
    localparam logic [7:0] DATA_TYPE = 8'h0F;
    localparam logic [7:0] COPY_MARK = 8'hFF;
    localparam logic [7:0] DEV_RESET = 8'h02;

    typedef enum logic [3:0] {
        S_HDR,
        S_DEV,
        S_COPY,
        S_CMD,
        S_TYPE,
        S_LEN,
        S_PAY,
        S_END,
        S_CHK
    } step_t;

    typedef struct packed {
        logic       start;
        logic       copy;
        logic       has_pay;
        logic       tail;
        logic [7:0] dev;
        logic [7:0] cmd;
        logic [7:0] ftype;
        logic [7:0] mid;
        logic [7:0] pay;
    } desc_t;

endpackage

`default_nettype wire

/* rtl/lfb_front.sv */
// Front end: accepts input words, tracks the open frame and builds job descriptors.
`timescale 1ns / 1ps
`default_nettype none

module lfb_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    command,
    input  wire logic [7:0]    frame_type,
    input  wire logic          copy_format,
    input  wire logic [7:0]    payload_len,
    input  wire logic [7:0]    payload_byte,
    input  wire logic [7:0]    dev_number,
    input  wire logic          q_full,
    output logic               q_push,
    output lfb_pkg::desc_t     q_desc
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic       is_data;
    logic       accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign is_data  = (frame_type == lfb_pkg::DATA_TYPE);

    always_comb
    begin
        q_desc.start   = !in_frame_reg;
        q_desc.copy    = copy_format;
        q_desc.dev     = dev_number;
        q_desc.cmd     = command;
        q_desc.ftype   = frame_type;
        q_desc.pay     = payload_byte;
        q_desc.mid     = is_data ? payload_len : (copy_format ? payload_byte : 8'h00);
        q_desc.has_pay = in_frame_reg || (is_data && (payload_len != 8'h00));
        q_desc.tail    = in_frame_reg ? (bytes_left_reg == 8'h01)
                                      : !(is_data && (payload_len > 8'h01));
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        if (accept)
        begin
            if (in_frame_reg)
            begin
                bytes_left_next = bytes_left_reg - 8'h01;
                in_frame_next   = (bytes_left_reg != 8'h01);
            end
            else if (is_data && (payload_len > 8'h01))
            begin
                in_frame_next   = 1'b1;
                bytes_left_next = payload_len - 8'h01;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'h00;
        end
        else
        begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

    // An open frame always waits for at least one more payload word.
    a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        in_frame_reg |-> (bytes_left_reg != 8'h00))
        else $error("open frame with no bytes left");

endmodule

`default_nettype wire

/* rtl/lfb_queue.sv */
// Short register queue of job descriptors between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module lfb_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire lfb_pkg::desc_t push_desc,
    output logic                full,
    output logic                head_valid,
    output lfb_pkg::desc_t      head_desc,
    input  wire logic           pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lfb_pkg::desc_t entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic           do_push;
    logic           do_pop;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/lfb_back.sv */
// Back end: walks each descriptor byte by byte into the output register with the check byte.
`timescale 1ns / 1ps
`default_nettype none

module lfb_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire lfb_pkg::desc_t head_desc,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          frame_byte,
    output logic                frame_last
);

    lfb_pkg::step_t step_reg;
    lfb_pkg::step_t step_next;
    lfb_pkg::step_t cur_step;
    logic           fresh_reg;
    logic           fresh_next;
    logic [7:0]     check_reg;
    logic [7:0]     check_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [7:0]     byte_reg;
    logic           last_reg;
    logic [7:0]     cur_byte;
    logic           done;
    logic           load;

    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign pop      = load && done;
    assign cur_step = fresh_reg ? (head_desc.start ? lfb_pkg::S_HDR : lfb_pkg::S_PAY)
                                : step_reg;

    // Next step of the byte sequencer.
    always_comb
    begin
        step_next  = step_reg;
        fresh_next = fresh_reg;
        if (load)
        begin
            fresh_next = done;
            case (cur_step)
                lfb_pkg::S_HDR:  step_next = lfb_pkg::S_DEV;
                lfb_pkg::S_DEV:  step_next = head_desc.copy ? lfb_pkg::S_COPY : lfb_pkg::S_CMD;
                lfb_pkg::S_COPY: step_next = lfb_pkg::S_CMD;
                lfb_pkg::S_CMD:  step_next = lfb_pkg::S_TYPE;
                lfb_pkg::S_TYPE: step_next = lfb_pkg::S_LEN;
                lfb_pkg::S_LEN:  step_next = head_desc.has_pay ? lfb_pkg::S_PAY : lfb_pkg::S_END;
                lfb_pkg::S_PAY:  step_next = lfb_pkg::S_END;
                lfb_pkg::S_END:  step_next = lfb_pkg::S_CHK;
                lfb_pkg::S_CHK:  step_next = lfb_pkg::S_HDR;
                default:         step_next = lfb_pkg::S_HDR;
            endcase
        end
    end

    // Byte produced in the current step.
    always_comb
    begin
        done = 1'b0;
        case (cur_step)
            lfb_pkg::S_HDR:  cur_byte = lfb_pkg::HDR_BYTE;
            lfb_pkg::S_DEV:  cur_byte = head_desc.dev;
            lfb_pkg::S_COPY: cur_byte = lfb_pkg::COPY_MARK;
            lfb_pkg::S_CMD:  cur_byte = head_desc.cmd;
            lfb_pkg::S_TYPE: cur_byte = head_desc.ftype;
            lfb_pkg::S_LEN:  cur_byte = head_desc.mid;
            lfb_pkg::S_PAY:
            begin
                cur_byte = head_desc.pay;
                done     = !head_desc.tail;
            end
            lfb_pkg::S_END:  cur_byte = lfb_pkg::END_BYTE;
            lfb_pkg::S_CHK:
            begin
                cur_byte = check_reg;
                done     = 1'b1;
            end
            default:         cur_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        check_next     = check_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (cur_step == lfb_pkg::S_HDR)
            begin
                check_next = cur_byte;
            end
            else if (cur_step == lfb_pkg::S_CHK)
            begin
                check_next = 8'h00;
            end
            else
            begin
                check_next = check_reg ^ cur_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= lfb_pkg::S_HDR;
            fresh_reg     <= 1'b1;
            check_reg     <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            fresh_reg     <= fresh_next;
            check_reg     <= check_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= cur_byte;
            last_reg <= (cur_step == lfb_pkg::S_CHK);
        end
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = byte_reg;
    assign frame_last = last_reg;

    // The check byte closes the job and leaves the sequencer waiting for a new one.
    a_chk_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (cur_step == lfb_pkg::S_CHK)) |=> (out_valid_reg && last_reg && fresh_reg))
        else $error("check byte did not close the frame");

    a_hdr_seeds_check: assert property (@(posedge clk) disable iff (!rst_n)
        (load && (cur_step == lfb_pkg::S_HDR)) |=> (check_reg == lfb_pkg::HDR_BYTE))
        else $error("check not seeded by header");

endmodule

`default_nettype wire

/* rtl/link_frame_builder.sv */
// A word passes through a queue entry register and the output byte register before its first byte is valid; the back
// end then sends one frame byte per cycle while a descriptor waits and out_stall is low. A start word sends header,
// device, copy mark if copy_format, command, type, length and any payload byte; a continuation word one payload byte;
// the last word of a frame adds the end and check bytes. Input words are taken while the descriptor queue has room,
// independent of output stalls. Reset clears the open-frame state, the queue, the check byte and sets dev_reg to 2.
`timescale 1ns / 1ps
`default_nettype none

module link_frame_builder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       dev_id_we,
    input  wire logic [7:0] dev_id,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] command,
    input  wire logic [7:0] frame_type,
    input  wire logic       copy_format,
    input  wire logic [7:0] payload_len,
    input  wire logic [7:0] payload_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      frame_byte,
    output logic            frame_last
);

    logic [7:0]     dev_reg;
    logic           q_push;
    logic           q_full;
    logic           q_pop;
    logic           head_valid;
    lfb_pkg::desc_t push_desc;
    lfb_pkg::desc_t head_desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= lfb_pkg::DEV_RESET;
        end
        else if (dev_id_we)
        begin
            dev_reg <= dev_id;
        end
    end

    lfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .frame_type   (frame_type),
        .copy_format  (copy_format),
        .payload_len  (payload_len),
        .payload_byte (payload_byte),
        .dev_number   (dev_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_desc       (push_desc)
    );

    lfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (push_desc),
        .full       (q_full),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (q_pop)
    );

    lfb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .frame_last (frame_last)
    );

endmodule

`default_nettype wire
